// ----- rtl/core/rtpq_pkg.sv -----
// rtp reorder queue package: entry type, cell control, result codes, sequence compare
package rtpq_pkg;

  localparam int SEQ_W = 16;
  localparam int HANDLE_W = 16;
  localparam int LEN_W = 11;
  localparam int KIND_W = 2;
  localparam int OCC_W = 7;

  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD        = 2'd0,
    CELL_INSERT      = 2'd1,
    CELL_INSERT_DROP = 2'd2,
    CELL_POP         = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic     capture;
    cell_op_t op;
  } cell_ctl_t;

  localparam logic [KIND_W-1:0] KIND_PUSH      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROP      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP       = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_EMPTY = 2'd3;

  // serial number order: x precedes y when (y - x) mod 2^16 lies in 1..0x7fff
  function automatic logic seq_precedes(input logic [SEQ_W-1:0] x,
                                        input logic [SEQ_W-1:0] y);
    logic [SEQ_W-1:0] diff;
    diff = y - x;
    return (diff != '0) && !diff[SEQ_W-1];
  endfunction

endpackage

// ----- rtl/core/rtpq_cell.sv -----
// one storage cell of the ordered chain: holds an entry and its compare flag
module rtpq_cell
  import rtpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      valid_in,
  input  entry_t    new_entry,
  input  entry_t    lower_entry,
  input  entry_t    upper_entry,
  input  logic      keep_low,
  input  logic      keep_self,
  input  logic      keep_up,
  output entry_t    entry,
  output logic      prec
);

  entry_t entry_next;

  always_comb begin
    entry_next = entry;
    case (ctl.op)
      CELL_INSERT: begin
        if (keep_self) begin
          entry_next = entry;
        end else if (keep_low) begin
          entry_next = new_entry;
        end else begin
          entry_next = lower_entry;
        end
      end
      CELL_INSERT_DROP: begin
        if (keep_up) begin
          entry_next = upper_entry;
        end else if (keep_self) begin
          entry_next = new_entry;
        end else begin
          entry_next = entry;
        end
      end
      CELL_POP: begin
        entry_next = upper_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prec <= 1'b0;
    end else if (ctl.capture) begin
      prec <= valid_in && seq_precedes(entry.seq, new_entry.seq);
    end
  end

endmodule

// ----- rtl/core/rtp_sequence_reorder_queue.sv -----
// top level of the rtp sequence reorder queue: control sequencer and chain of cells
// Holds up to QUEUE_DEPTH-1 packet descriptors in a chain of cells kept in RTP
// serial number order, oldest in cell 0. Each item goes through the states in order:
// the idle state takes the transfer, in the compare state every cell compares its
// sequence number against the new one in parallel, and in the apply state the chain
// shifts (insert, insert with drop of the oldest, or pop) and the result is loaded
// into the output register. The apply state waits while a previous result is still
// held by the receiver. A push that brings the queue to QUEUE_DEPTH entries drops
// and reports the oldest. Occupancy reports the low 7 bits of the entry count.
module rtp_sequence_reorder_queue
  import rtpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic [SEQ_W-1:0]    sequence_number,
  input  logic [HANDLE_W-1:0] packet_handle,
  input  logic [LEN_W-1:0]    packet_length,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KIND_W-1:0]   result_kind,
  output logic [SEQ_W-1:0]    out_sequence,
  output logic [HANDLE_W-1:0] out_handle,
  output logic [LEN_W-1:0]    out_length,
  output logic [OCC_W-1:0]    occupancy
);

  localparam int CW = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_COMPARE = 3'b010,
    ST_APPLY   = 3'b100
  } state_t;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  entry_t new_entry;
  logic op_pop;

  entry_t cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] prec;
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH:0] keep;
  cell_ctl_t ctl;

  logic in_xfer;
  logic apply_fire;
  logic [KIND_W-1:0] kind_next;
  entry_t res_entry;

  assign in_stall = (state != ST_IDLE);
  assign in_xfer = in_valid && !in_stall;
  assign apply_fire = (state == ST_APPLY) && !(out_valid && out_stall);

  assign keep[QUEUE_DEPTH] = 1'b0;

  for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
    entry_t lower_entry;
    entry_t upper_entry;
    logic keep_low;

    assign cell_valid[j] = (CW'(j) < count);
    assign keep[j] = |prec[QUEUE_DEPTH-1:j];

    if (j == 0) begin : g_bottom
      assign lower_entry = '0;
      assign keep_low = 1'b1;
    end else begin : g_lower
      assign lower_entry = cell_entry[j-1];
      assign keep_low = keep[j-1];
    end

    if (j == QUEUE_DEPTH - 1) begin : g_top
      assign upper_entry = '0;
    end else begin : g_upper
      assign upper_entry = cell_entry[j+1];
    end

    rtpq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .valid_in   (cell_valid[j]),
      .new_entry  (new_entry),
      .lower_entry(lower_entry),
      .upper_entry(upper_entry),
      .keep_low   (keep_low),
      .keep_self  (keep[j]),
      .keep_up    (keep[j+1]),
      .entry      (cell_entry[j]),
      .prec       (prec[j])
    );
  end

  always_comb begin
    ctl.capture = (state == ST_COMPARE);
    ctl.op = CELL_HOLD;
    count_next = count;
    kind_next = KIND_PUSH;
    res_entry = '0;
    if (op_pop) begin
      if (count == '0) begin
        kind_next = KIND_POP_EMPTY;
      end else begin
        kind_next = KIND_POP;
        res_entry = cell_entry[0];
        count_next = count - 1'b1;
        ctl.op = apply_fire ? CELL_POP : CELL_HOLD;
      end
    end else if (count == CW'(QUEUE_DEPTH - 1)) begin
      kind_next = KIND_DROP;
      res_entry = keep[0] ? cell_entry[0] : new_entry;
      ctl.op = apply_fire ? CELL_INSERT_DROP : CELL_HOLD;
    end else begin
      count_next = count + 1'b1;
      ctl.op = apply_fire ? CELL_INSERT : CELL_HOLD;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) state_next = ST_COMPARE;
      end
      ST_COMPARE: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (apply_fire) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_fire) begin
        count <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_pop <= mode;
      new_entry <= '{seq: sequence_number, handle: packet_handle, len: packet_length};
    end
    if (apply_fire) begin
      result_kind <= kind_next;
      out_sequence <= res_entry.seq;
      out_handle <= res_entry.handle;
      out_length <= res_entry.len;
      occupancy <= OCC_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH - 1))
    else $error("entry count beyond queue depth");

  a_result_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_APPLY))
    else $error("result loaded outside apply step");

  a_accept_starts_compare: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == ST_COMPARE)
    else $error("accepted transfer did not start compare");

  a_drop_at_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_DROP) |-> occupancy == OCC_W'(QUEUE_DEPTH - 1))
    else $error("drop reported below full occupancy");

endmodule
